// ----- rtl/core/p2pd_pkg.sv -----
// Shared types and fixed widths for the perspective-to-planar depth core.
// No dependencies; used by every module of the core by scoped names.
package p2pd_pkg;

    localparam int FocalW = 16;  // focal length register
    localparam int DimW   = 13;  // image width and height registers
    localparam int CoordW = 12;  // pixel column and row
    localparam int OffW   = 14;  // magnitude of a doubled offset from the center
    localparam int DsumW  = 35;  // 4*f^2 + dx^2 + dy^2
    localparam int IdxW   = 2;   // register index on the configuration port

    localparam logic [IdxW-1:0] CfgFocal  = 2'd0;
    localparam logic [IdxW-1:0] CfgWidth  = 2'd1;
    localparam logic [IdxW-1:0] CfgHeight = 2'd2;

    typedef struct packed {
        logic [FocalW-1:0] focal;
        logic [DimW-1:0]   width;
        logic [DimW-1:0]   height;
    } t_cfg;

endpackage

// ----- rtl/core/p2pd_prep.sv -----
// Front stages: center offsets, squares and the two sides of the comparison.
// Depends on p2pd_pkg. Three register stages, all advanced by one enable.
module p2pd_prep #(
    parameter int DEPTH_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  p2pd_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    input  logic [DEPTH_BITS-1:0]          i_depth,
    input  logic [p2pd_pkg::CoordW-1:0]    i_column,
    input  logic [p2pd_pkg::CoordW-1:0]    i_row,
    output logic                           o_valid,
    output logic [DEPTH_BITS-1:0]          o_depth,
    output logic [p2pd_pkg::DsumW-1:0]     o_dsum,
    output logic [2*DEPTH_BITS+33:0]       o_rhs
);
    localparam int FdW  = p2pd_pkg::FocalW + DEPTH_BITS;
    localparam int OffW = p2pd_pkg::OffW;
    localparam int DimW = p2pd_pkg::DimW;
    localparam logic [16:0] MaxDim = 17'(MAX_DIM);

    logic [DimW-1:0]  n_wc, n_hc;
    logic [OffW-1:0]  n_dx, n_dy;

    logic                          r1_valid, r2_valid, r3_valid;
    logic [DEPTH_BITS-1:0]         r1_depth, r2_depth, r3_depth;
    logic [OffW-1:0]               r1_dx, r1_dy;
    logic [p2pd_pkg::FocalW-1:0]   r1_f;
    logic [FdW-1:0]                r1_fd;
    logic [31:0]                   r2_ff;
    logic [2*OffW-1:0]             r2_dx2, r2_dy2;
    logic [2*FdW-1:0]              r2_t2;
    logic [p2pd_pkg::DsumW-1:0]    r3_dsum;
    logic [2*DEPTH_BITS+33:0]      r3_rhs;

    function automatic logic [OffW-1:0] offset_mag(logic [p2pd_pkg::CoordW-1:0] p,
                                                   logic [DimW-1:0] dim);
        logic [OffW:0] off;
        off = {2'b00, p, 1'b0} + (OffW+1)'(2) - {2'b00, dim};
        return off[OffW] ? OffW'(~off + 1'b1) : off[OffW-1:0];
    endfunction

    // Dimensions beyond the supported maximum are treated as the maximum.
    assign n_wc = ({4'b0, i_cfg.width}  > MaxDim) ? MaxDim[DimW-1:0] : i_cfg.width;
    assign n_hc = ({4'b0, i_cfg.height} > MaxDim) ? MaxDim[DimW-1:0] : i_cfg.height;
    assign n_dx = offset_mag(i_column, n_wc);
    assign n_dy = offset_mag(i_row, n_hc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_depth <= i_depth;
            r1_dx    <= n_dx;
            r1_dy    <= n_dy;
            r1_f     <= i_cfg.focal;
            r1_fd    <= FdW'(i_cfg.focal * i_depth);

            r2_depth <= r1_depth;
            r2_ff    <= 32'(r1_f * r1_f);
            r2_dx2   <= (2*OffW)'(r1_dx * r1_dx);
            r2_dy2   <= (2*OffW)'(r1_dy * r1_dy);
            r2_t2    <= (2*FdW)'(r1_fd * r1_fd);

            r3_depth <= r2_depth;
            r3_dsum  <= {1'b0, r2_ff, 2'b00} + p2pd_pkg::DsumW'(r2_dx2)
                        + p2pd_pkg::DsumW'(r2_dy2);
            r3_rhs   <= {r2_t2, 2'b00};
        end
    end

    assign o_valid = r3_valid;
    assign o_depth = r3_depth;
    assign o_dsum  = r3_dsum;
    assign o_rhs   = r3_rhs;
endmodule

// ----- rtl/core/p2pd_sqrt_stage.sv -----
// One bit of the root search: tries q + 2^BIT against the right-hand side.
// Depends on p2pd_pkg. Keeps q^2*D and q*D so each try is adds and shifts only.
module p2pd_sqrt_stage #(
    parameter int DEPTH_BITS = 16,
    parameter int BIT        = 15
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [DEPTH_BITS-1:0]                   i_depth,
    input  logic [p2pd_pkg::DsumW-1:0]              i_dsum,
    input  logic [2*DEPTH_BITS+33:0]                i_rhs,
    input  logic [DEPTH_BITS-1:0]                   i_q,
    input  logic [2*DEPTH_BITS+p2pd_pkg::DsumW-1:0] i_qqd,
    input  logic [DEPTH_BITS+p2pd_pkg::DsumW-1:0]   i_qd,
    output logic                                    o_valid,
    output logic [DEPTH_BITS-1:0]                   o_depth,
    output logic [p2pd_pkg::DsumW-1:0]              o_dsum,
    output logic [2*DEPTH_BITS+33:0]                o_rhs,
    output logic [DEPTH_BITS-1:0]                   o_q,
    output logic [2*DEPTH_BITS+p2pd_pkg::DsumW-1:0] o_qqd,
    output logic [DEPTH_BITS+p2pd_pkg::DsumW-1:0]   o_qd
);
    localparam int CW = 2*DEPTH_BITS + p2pd_pkg::DsumW;
    localparam int SW = DEPTH_BITS + p2pd_pkg::DsumW;

    logic [CW-1:0] n_cand;
    logic          n_fits;
    logic          r_valid;
    logic [DEPTH_BITS-1:0]         r_depth, r_q;
    logic [p2pd_pkg::DsumW-1:0]    r_dsum;
    logic [2*DEPTH_BITS+33:0]      r_rhs;
    logic [CW-1:0]                 r_qqd;
    logic [SW-1:0]                 r_qd;

    // (q + 2^b)^2 * D = q^2*D + 2^(b+1)*q*D + 2^(2b)*D; the lower bits of q are
    // still zero, so the sum stays below 2^(2N) * D and fits the width.
    assign n_cand = i_qqd + (CW'(i_qd) << (BIT + 1)) + (CW'(i_dsum) << (2 * BIT));
    assign n_fits = n_cand <= CW'(i_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_depth <= i_depth;
            r_dsum  <= i_dsum;
            r_rhs   <= i_rhs;
            if (n_fits) begin
                r_q   <= i_q | (DEPTH_BITS'(1) << BIT);
                r_qqd <= n_cand;
                r_qd  <= i_qd + (SW'(i_dsum) << BIT);
            end else begin
                r_q   <= i_q;
                r_qqd <= i_qqd;
                r_qd  <= i_qd;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_depth = r_depth;
    assign o_dsum  = r_dsum;
    assign o_rhs   = r_rhs;
    assign o_q     = r_q;
    assign o_qqd   = r_qqd;
    assign o_qd    = r_qd;
endmodule

// ----- rtl/core/perspective_to_planar_depth_core.sv -----
// Top level of the perspective-to-planar depth core: config registers,
// pipeline of p2pd_prep and DEPTH_BITS p2pd_sqrt_stage, output skid buffer.
//
//  channel  direction  beat contents (low bits first)             accepted when
//  s        in         depth_in, column, row                      i_s_tvalid & o_s_tready
//  m        out        plane_depth                                o_m_tvalid & i_m_tready
//  cfg      in         register index (0 focal, 1 width, 2 height) i_cfg_valid & o_cfg_ready
//
// One beat is taken every cycle while the output side keeps up. A beat passes
// through three front stages, one root-search stage per result bit, and the
// output register. A stall on the m side fills a single spare register;
// o_s_tready drops only then, so no downstream ready reaches the input
// combinationally. Reset (synchronous, active low) clears all valid bits
// and returns the registers to focal length 128 and a 256 x 256 image.
module perspective_to_planar_depth_core #(
    parameter int DEPTH_BITS = 16,
    parameter int MAX_DIM    = 4096
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // depth_in [DEPTH_BITS-1:0], column [+12], row [+12], zero pad to bytes
    input  logic [((DEPTH_BITS+2*p2pd_pkg::CoordW+7)/8)*8-1:0] i_s_tdata,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // plane_depth [DEPTH_BITS-1:0], zero pad to bytes
    output logic [((DEPTH_BITS+7)/8)*8-1:0]               o_m_tdata,
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [p2pd_pkg::IdxW-1:0]                     i_cfg_addr,
    input  logic [15:0]                                   i_cfg_data
);
    localparam int N      = DEPTH_BITS;
    localparam int CoordW = p2pd_pkg::CoordW;
    localparam int DsumW  = p2pd_pkg::DsumW;
    localparam int CW     = 2*N + DsumW;
    localparam int SW     = N + DsumW;
    localparam int OutW   = ((N+7)/8)*8;

    p2pd_pkg::t_cfg r_cfg;

    // The configuration channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal  <= 16'd128;
            r_cfg.width  <= 13'd256;
            r_cfg.height <= 13'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                p2pd_pkg::CfgFocal:  r_cfg.focal  <= i_cfg_data;
                p2pd_pkg::CfgWidth:  r_cfg.width  <= i_cfg_data[p2pd_pkg::DimW-1:0];
                p2pd_pkg::CfgHeight: r_cfg.height <= i_cfg_data[p2pd_pkg::DimW-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances while the spare register is empty.
    logic r_full;
    logic en;
    assign en         = !r_full;
    assign o_s_tready = en;

    logic                  c_valid [0:N];
    logic [N-1:0]          c_depth [0:N];
    logic [DsumW-1:0]      c_dsum  [0:N];
    logic [2*N+33:0]       c_rhs   [0:N];
    logic [N-1:0]          c_q     [0:N];
    logic [CW-1:0]         c_qqd   [0:N];
    logic [SW-1:0]         c_qd    [0:N];

    p2pd_prep #(
        .DEPTH_BITS(N),
        .MAX_DIM   (MAX_DIM)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .i_depth (i_s_tdata[N-1:0]),
        .i_column(i_s_tdata[N+CoordW-1:N]),
        .i_row   (i_s_tdata[N+2*CoordW-1:N+CoordW]),
        .o_valid (c_valid[0]),
        .o_depth (c_depth[0]),
        .o_dsum  (c_dsum[0]),
        .o_rhs   (c_rhs[0])
    );

    assign c_q[0]   = '0;
    assign c_qqd[0] = '0;
    assign c_qd[0]  = '0;

    // Result bits are decided from the most significant one down.
    for (genvar k = 0; k < N; k++) begin : g_search
        p2pd_sqrt_stage #(
            .DEPTH_BITS(N),
            .BIT       (N - 1 - k)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(c_valid[k]),
            .i_depth(c_depth[k]),
            .i_dsum (c_dsum[k]),
            .i_rhs  (c_rhs[k]),
            .i_q    (c_q[k]),
            .i_qqd  (c_qqd[k]),
            .i_qd   (c_qd[k]),
            .o_valid(c_valid[k+1]),
            .o_depth(c_depth[k+1]),
            .o_dsum (c_dsum[k+1]),
            .o_rhs  (c_rhs[k+1]),
            .o_q    (c_q[k+1]),
            .o_qqd  (c_qqd[k+1]),
            .o_qd   (c_qd[k+1])
        );
    end

    // With a nonzero focal length the root never exceeds the depth. With a zero
    // focal length at the exact center every candidate fits, and the depth
    // itself is the answer; the cap covers both.
    logic [N-1:0] n_result;
    assign n_result = (c_q[N] > c_depth[N]) ? c_depth[N] : c_q[N];

    logic         push;
    logic         r_out_valid;
    logic [N-1:0] r_out, r_spare;
    assign push = en && c_valid[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_full      <= 1'b0;
        end else if (i_m_tready || !r_out_valid) begin
            r_out_valid <= r_full || push;
            r_full      <= 1'b0;
        end else if (push) begin
            r_full      <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_m_tready || !r_out_valid) begin
            r_out <= r_full ? r_spare : n_result;
        end else if (push) begin
            r_spare <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OutW'(r_out);

    // The spare register holds a beat only behind a waiting output beat.
    a_spare_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_out_valid)
        else $error("spare register full while output is empty");

    // A finished beat leaving the pipeline is never dropped.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_out_valid || r_full))
        else $error("pipeline beat lost at the output");

    // Once the spare fills, the input side stays closed until the output moves.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_m_tready) |=> r_full)
        else $error("spare register drained without an output handshake");
endmodule
